>>> sv/smin_pkg.sv
// Package for the script source minifier: byte codes, scan modes and the
// result group that passes from the scan stage to the output drain. No dependencies.
package smin_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int unsigned GRP_SLOTS = 4;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_DOC     = 2'd2
  } mode_t;

  // Up to four result items produced by one input item.
  typedef struct packed {
    logic [GRP_SLOTS-1:0][7:0] chars;
    logic [2:0]                count;
    logic                      bare;
    logic                      last;
  } group_t;

  // Append one byte in the next free slot.
  function automatic group_t grp_push(group_t g, logic [7:0] ch);
    group_t r;
    r = g;
    r.chars[g.count[1:0]] = ch;
    r.count = g.count + 3'd1;
    return r;
  endfunction

endpackage

>>> sv/smin_scan.sv
// Scan stage of the minifier: input register, scan state and the logic that
// builds one result group per item. Depends on smin_pkg.
module smin_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_char,
  input  logic            end_of_text,
  input  logic            grp_free,
  output logic            grp_load,
  output smin_pkg::group_t grp
);
  import smin_pkg::*;

  logic       valid_r;
  logic [7:0] char_r;
  logic       last_r;

  mode_t      mode, mode_next;
  logic [1:0] open_q, open_q_next;
  logic [1:0] close_q, close_q_next;
  logic       space_pending, space_pending_next;
  logic       any_emitted, any_emitted_next;

  logic       advance;

  assign advance  = valid_r && grp_free;
  assign in_ready = !valid_r || advance;
  assign grp_load = advance && (grp.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r       <= 1'b0;
      mode          <= MODE_NORMAL;
      open_q        <= 2'd0;
      close_q       <= 2'd0;
      space_pending <= 1'b0;
      any_emitted   <= 1'b0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (advance) begin
        mode          <= mode_next;
        open_q        <= open_q_next;
        close_q       <= close_q_next;
        space_pending <= space_pending_next;
        any_emitted   <= any_emitted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char;
      last_r <= end_of_text;
    end
  end

  always_comb begin
    group_t g;
    logic   is_ws;
    g                  = '0;
    mode_next          = mode;
    open_q_next        = open_q;
    close_q_next       = close_q;
    space_pending_next = space_pending;
    any_emitted_next   = any_emitted;
    is_ws = (char_r == CH_NL) || (char_r == CH_TAB) || (char_r == CH_SP);

    case (mode)
      MODE_COMMENT: begin
        if (char_r == CH_NL) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_DOC: begin
        if (char_r == CH_QUOTE) begin
          if (close_q == 2'd2) begin
            close_q_next = 2'd0;
            mode_next    = MODE_NORMAL;
          end else begin
            close_q_next = close_q + 2'd1;
          end
        end else begin
          close_q_next = 2'd0;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        if (char_r == CH_QUOTE) begin
          if (open_q == 2'd2) begin
            open_q_next  = 2'd0;
            close_q_next = 2'd0;
            mode_next    = MODE_DOC;
          end else begin
            open_q_next = open_q + 2'd1;
          end
        end else begin
          // release held quotes, the first preceded by a pending space if any
          for (int q = 0; q < 2; q++) begin
            if (2'(q) < open_q) begin
              if (space_pending_next) begin
                g = grp_push(g, CH_SP);
                space_pending_next = 1'b0;
              end
              g = grp_push(g, CH_QUOTE);
              any_emitted_next = 1'b1;
            end
          end
          open_q_next = 2'd0;
          if (char_r == CH_HASH) begin
            mode_next = MODE_COMMENT;
          end else if (is_ws) begin
            if (any_emitted_next) begin
              space_pending_next = 1'b1;
            end
          end else begin
            if (space_pending_next) begin
              g = grp_push(g, CH_SP);
              space_pending_next = 1'b0;
            end
            g = grp_push(g, char_r);
            any_emitted_next = 1'b1;
          end
        end
      end
    endcase

    if (last_r) begin
      if (mode_next == MODE_NORMAL) begin
        for (int q = 0; q < 2; q++) begin
          if (2'(q) < open_q_next) begin
            if (space_pending_next) begin
              g = grp_push(g, CH_SP);
              space_pending_next = 1'b0;
            end
            g = grp_push(g, CH_QUOTE);
          end
        end
      end
      if (g.count == 3'd0) begin
        g      = grp_push(g, CH_NUL);
        g.bare = 1'b1;
      end
      g.last             = 1'b1;
      mode_next          = MODE_NORMAL;
      open_q_next        = 2'd0;
      close_q_next       = 2'd0;
      space_pending_next = 1'b0;
      any_emitted_next   = 1'b0;
    end
    grp = g;
  end

endmodule

>>> sv/smin_drain.sv
// Output drain of the minifier: holds one result group and hands its items
// out one per cycle while out_ready is high. Depends on smin_pkg.
module smin_drain (
  input  logic             clk,
  input  logic             rst,
  input  logic             grp_load,
  input  smin_pkg::group_t grp,
  output logic             grp_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic             has_char,
  output logic             end_of_output
);
  import smin_pkg::*;

  logic                      held;
  logic [1:0]                idx;
  logic [1:0]                last_idx;
  logic [GRP_SLOTS-1:0][7:0] chars;
  logic                      bare;
  logic                      endm;
  logic                      at_last;

  assign at_last  = (idx == last_idx);
  assign grp_free = !held || (out_ready && at_last);

  assign out_valid     = held;
  assign out_char      = chars[idx];
  assign has_char      = !bare;
  assign end_of_output = endm && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 2'd0;
    end else if (grp_free) begin
      held <= grp_load;
      idx  <= 2'd0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_free && grp_load) begin
      chars    <= grp.chars;
      last_idx <= 2'(grp.count - 3'd1);
      bare     <= grp.bare;
      endm     <= grp.last;
    end
  end

endmodule

>>> sv/script_source_minifier_core.sv
// Top level of the script source minifier: joins the scan stage and the
// output drain. Depends on smin_pkg, smin_scan and smin_drain.
//
// The block takes source bytes on the input channel and returns the
// minified byte stream on the output channel. Whitespace runs collapse to
// one space, hash comments and triple-quoted docstrings are dropped, and
// leading and trailing spaces are trimmed. Mark the final byte of a text
// with end_of_text; the last result of that text carries end_of_output,
// and a text that yields no bytes still produces one bare end marker
// (has_char low). All scan state returns to its reset value after it.
// Timing: an accepted item is registered in the input register; once the
// output group is free, the scan logic updates the state and loads its
// results (zero to four items) into the output group register, which
// drives the output ports directly. Plain text streams at one byte per
// cycle while out_ready is high; an item that releases held quotes or a
// pending space occupies the output group until each of its result items
// is taken, and the input stalls until the last of them is taken. The next
// group loads in the same cycle the last item of the previous one leaves.
module script_source_minifier_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       end_of_output
);
  import smin_pkg::*;

  group_t grp;
  logic   grp_load;
  logic   grp_free;

  // scan state and group build
  smin_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .grp_free    (grp_free),
    .grp_load    (grp_load),
    .grp         (grp)
  );

  // hold the group and hand out its items in order
  smin_drain u_drain (
    .clk           (clk),
    .rst           (rst),
    .grp_load      (grp_load),
    .grp           (grp),
    .grp_free      (grp_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .has_char      (has_char),
    .end_of_output (end_of_output)
  );

endmodule
